// ----- rtl/tlsh_pkg.sv -----
// Shared types and constants for the hello message parser.
// Used by tlsh_core, tls_hello_parser and tlsh_checker; depends on nothing.
package tlsh_pkg;

    // Duplicate check table depth and derived widths
    localparam int MAX_EXTENSIONS = 16;
    localparam int SEEN_CNT_W     = $clog2(MAX_EXTENSIONS + 1);
    localparam int SEEN_IDX_W     = (MAX_EXTENSIONS > 1) ? $clog2(MAX_EXTENSIONS) : 1;

    // Fixed field lengths
    localparam logic [15:0] RANDOM_LEN      = 16'd32;
    localparam logic [7:0]  SESSION_MAX_LEN = 8'd32;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 4;

    // Parser position in the body
    typedef enum logic [3:0] {
        PH_VER   = 4'd0,
        PH_RAND  = 4'd1,
        PH_SLEN  = 4'd2,
        PH_SESS  = 4'd3,
        PH_CSLEN = 4'd4,
        PH_CS    = 4'd5,
        PH_CMLEN = 4'd6,
        PH_CM    = 4'd7,
        PH_SUITE = 4'd8,
        PH_SCOMP = 4'd9,
        PH_XLEN  = 4'd10,
        PH_XTYPE = 4'd11,
        PH_XDLEN = 4'd12,
        PH_XDATA = 4'd13,
        PH_TAIL  = 4'd14,
        PH_ERR   = 4'd15
    } phase_t;

    // Tag carried with each byte
    typedef enum logic [3:0] {
        FC_VERSION   = 4'd0,
        FC_RANDOM    = 4'd1,
        FC_SESS_LEN  = 4'd2,
        FC_SESS      = 4'd3,
        FC_SUITES_LEN = 4'd4,
        FC_SUITES    = 4'd5,
        FC_COMP_LEN  = 4'd6,
        FC_COMP      = 4'd7,
        FC_SUITE     = 4'd8,
        FC_EXT_LIST_LEN = 4'd9,
        FC_EXT_TYPE  = 4'd10,
        FC_EXT_LEN   = 4'd11,
        FC_EXT_DATA  = 4'd12,
        FC_AFTER_ERR = 4'd13
    } field_code_t;

    // Verdict codes
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_TRUNCATED  = 3'd1,
        ERR_SESS_LONG  = 3'd2,
        ERR_SUITES_LEN = 3'd3,
        ERR_COMP_EMPTY = 3'd4,
        ERR_DUP_EXT    = 3'd5,
        ERR_TRAILING   = 3'd6,
        ERR_TABLE_FULL = 3'd7
    } error_t;

    // Per-byte result handed from the parser to the output register
    typedef struct packed {
        field_code_t field_code;
        logic        done;
        logic        accepted;
        error_t      error_code;
        logic [15:0] version;
        logic [15:0] suite;
    } tlsh_result_t;

    // Tag of the field a byte belongs to, from the phase it arrives in
    function automatic field_code_t tag_of_phase(input phase_t ph);
        field_code_t tag;
        case (ph)
            PH_VER:   tag = FC_VERSION;
            PH_RAND:  tag = FC_RANDOM;
            PH_SLEN:  tag = FC_SESS_LEN;
            PH_SESS:  tag = FC_SESS;
            PH_CSLEN: tag = FC_SUITES_LEN;
            PH_CS:    tag = FC_SUITES;
            PH_CMLEN: tag = FC_COMP_LEN;
            PH_CM:    tag = FC_COMP;
            PH_SUITE: tag = FC_SUITE;
            PH_SCOMP: tag = FC_COMP;
            PH_XLEN:  tag = FC_EXT_LIST_LEN;
            PH_XTYPE: tag = FC_EXT_TYPE;
            PH_XDLEN: tag = FC_EXT_LEN;
            PH_XDATA: tag = FC_EXT_DATA;
            default:  tag = FC_AFTER_ERR;
        endcase
        return tag;
    endfunction

endpackage

// ----- rtl/tlsh_core.sv -----
// Hello body parse engine: field walker, length counters and extension type table.
// Depends on tlsh_pkg. Updates its state by one byte whenever step is high.
module tlsh_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    input  logic                  expect_client,
    output tlsh_pkg::tlsh_result_t res
);
    import tlsh_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] field_rem_reg, field_rem_next;
    logic [15:0] list_rem_reg, list_rem_next;
    logic [7:0]  acc_hi_reg, acc_hi_next;
    logic [SEEN_CNT_W-1:0] seen_count_reg, seen_count_next;
    error_t      first_err_reg, first_err_next;
    logic [15:0] version_reg, version_next;
    logic [15:0] suite_reg, suite_next;

    logic [15:0] seen_types_reg [MAX_EXTENSIONS];
    logic        table_wr;

    logic [15:0] pair_value;
    logic        pair_done;
    logic [15:0] list_dec;
    logic        dup_hit;
    logic        at_end;
    error_t      err_final;

    assign pair_value = {acc_hi_reg, in_byte};
    assign pair_done  = (field_rem_reg != 16'd0);
    assign list_dec   = list_rem_reg - 16'd1;

    // Parallel compare of the new type against stored types
    always_comb begin
        dup_hit = 1'b0;
        for (int i = 0; i < MAX_EXTENSIONS; i++) begin
            if ((int'(seen_count_reg) > i) && (seen_types_reg[i] == pair_value)) begin
                dup_hit = 1'b1;
            end
        end
    end

    // Next state of the field walker
    always_comb begin
        phase_next      = phase_reg;
        field_rem_next  = field_rem_reg;
        list_rem_next   = list_rem_reg;
        acc_hi_next     = acc_hi_reg;
        seen_count_next = seen_count_reg;
        first_err_next  = first_err_reg;
        version_next    = version_reg;
        suite_next      = suite_reg;
        table_wr        = 1'b0;

        case (phase_reg)
            PH_VER: begin
                if (!pair_done) begin
                    acc_hi_next    = in_byte;
                    field_rem_next = 16'd1;
                end else begin
                    version_next   = pair_value;
                    phase_next     = PH_RAND;
                    field_rem_next = RANDOM_LEN;
                end
            end
            PH_RAND: begin
                if (field_rem_reg <= 16'd1) begin
                    phase_next     = PH_SLEN;
                    field_rem_next = 16'd0;
                end else begin
                    field_rem_next = field_rem_reg - 16'd1;
                end
            end
            PH_SLEN: begin
                if (in_byte > SESSION_MAX_LEN) begin
                    first_err_next = ERR_SESS_LONG;
                    phase_next     = PH_ERR;
                end else if (in_byte == 8'd0) begin
                    phase_next     = expect_client ? PH_CSLEN : PH_SUITE;
                    field_rem_next = 16'd0;
                end else begin
                    phase_next     = PH_SESS;
                    field_rem_next = {8'd0, in_byte};
                end
            end
            PH_SESS: begin
                if (field_rem_reg <= 16'd1) begin
                    phase_next     = expect_client ? PH_CSLEN : PH_SUITE;
                    field_rem_next = 16'd0;
                end else begin
                    field_rem_next = field_rem_reg - 16'd1;
                end
            end
            PH_CSLEN: begin
                if (!pair_done) begin
                    acc_hi_next    = in_byte;
                    field_rem_next = 16'd1;
                end else if ((pair_value == 16'd0) || pair_value[0]) begin
                    field_rem_next = 16'd0;
                    first_err_next = ERR_SUITES_LEN;
                    phase_next     = PH_ERR;
                end else begin
                    phase_next     = PH_CS;
                    field_rem_next = pair_value;
                end
            end
            PH_CS: begin
                if (field_rem_reg <= 16'd1) begin
                    phase_next     = PH_CMLEN;
                    field_rem_next = 16'd0;
                end else begin
                    field_rem_next = field_rem_reg - 16'd1;
                end
            end
            PH_CMLEN: begin
                if (in_byte == 8'd0) begin
                    first_err_next = ERR_COMP_EMPTY;
                    phase_next     = PH_ERR;
                end else begin
                    phase_next     = PH_CM;
                    field_rem_next = {8'd0, in_byte};
                end
            end
            PH_CM: begin
                if (field_rem_reg <= 16'd1) begin
                    phase_next     = PH_XLEN;
                    field_rem_next = 16'd0;
                end else begin
                    field_rem_next = field_rem_reg - 16'd1;
                end
            end
            PH_SUITE: begin
                if (!pair_done) begin
                    acc_hi_next    = in_byte;
                    field_rem_next = 16'd1;
                end else begin
                    suite_next     = pair_value;
                    phase_next     = PH_SCOMP;
                    field_rem_next = 16'd0;
                end
            end
            PH_SCOMP: begin
                phase_next     = PH_XLEN;
                field_rem_next = 16'd0;
            end
            PH_XLEN: begin
                if (!pair_done) begin
                    acc_hi_next    = in_byte;
                    field_rem_next = 16'd1;
                end else begin
                    list_rem_next  = pair_value;
                    field_rem_next = 16'd0;
                    phase_next     = (pair_value == 16'd0) ? PH_TAIL : PH_XTYPE;
                end
            end
            PH_XTYPE, PH_XDLEN, PH_XDATA: begin
                if (list_rem_reg == 16'd0) begin
                    first_err_next = ERR_TRUNCATED;
                    phase_next     = PH_ERR;
                end else begin
                    list_rem_next = list_dec;
                    if (phase_reg == PH_XDATA) begin
                        if (field_rem_reg <= 16'd1) begin
                            phase_next     = (list_dec == 16'd0) ? PH_TAIL : PH_XTYPE;
                            field_rem_next = 16'd0;
                        end else begin
                            field_rem_next = field_rem_reg - 16'd1;
                        end
                    end else if (!pair_done) begin
                        // first byte of a type or length
                        acc_hi_next    = in_byte;
                        field_rem_next = 16'd1;
                        if (list_dec == 16'd0) begin
                            first_err_next = ERR_TRUNCATED;
                            phase_next     = PH_ERR;
                        end
                    end else if (phase_reg == PH_XTYPE) begin
                        field_rem_next = 16'd0;
                        if (list_dec == 16'd0) begin
                            first_err_next = ERR_TRUNCATED;
                            phase_next     = PH_ERR;
                        end else if (dup_hit) begin
                            first_err_next = ERR_DUP_EXT;
                            phase_next     = PH_ERR;
                        end else if (int'(seen_count_reg) >= MAX_EXTENSIONS) begin
                            first_err_next = ERR_TABLE_FULL;
                            phase_next     = PH_ERR;
                        end else begin
                            table_wr        = 1'b1;
                            seen_count_next = seen_count_reg + 1'b1;
                            phase_next      = PH_XDLEN;
                        end
                    end else begin
                        // extension data length
                        field_rem_next = 16'd0;
                        if (pair_value > list_dec) begin
                            first_err_next = ERR_TRUNCATED;
                            phase_next     = PH_ERR;
                        end else if (pair_value == 16'd0) begin
                            phase_next = (list_dec == 16'd0) ? PH_TAIL : PH_XTYPE;
                        end else begin
                            phase_next     = PH_XDATA;
                            field_rem_next = pair_value;
                        end
                    end
                end
            end
            PH_TAIL: begin
                first_err_next = ERR_TRAILING;
                phase_next     = PH_ERR;
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Verdict and per-byte result
    always_comb begin
        at_end = ((phase_next == PH_XLEN) && (field_rem_next == 16'd0)) ||
                 (phase_next == PH_TAIL);
        err_final = ((first_err_next == ERR_NONE) && !at_end) ? ERR_TRUNCATED
                                                               : first_err_next;
        res.field_code = tag_of_phase(phase_reg);
        res.done       = in_last;
        res.accepted   = in_last && (err_final == ERR_NONE);
        res.error_code = in_last ? err_final : ERR_NONE;
        res.version    = version_next;
        res.suite      = suite_next;
    end

    // Parser state; cleared after the last byte of a body
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_VER;
            field_rem_reg  <= '0;
            list_rem_reg   <= '0;
            acc_hi_reg     <= '0;
            seen_count_reg <= '0;
            first_err_reg  <= ERR_NONE;
            version_reg    <= '0;
            suite_reg      <= '0;
        end else if (step) begin
            if (in_last) begin
                phase_reg      <= PH_VER;
                field_rem_reg  <= '0;
                list_rem_reg   <= '0;
                acc_hi_reg     <= '0;
                seen_count_reg <= '0;
                first_err_reg  <= ERR_NONE;
                version_reg    <= '0;
                suite_reg      <= '0;
            end else begin
                phase_reg      <= phase_next;
                field_rem_reg  <= field_rem_next;
                list_rem_reg   <= list_rem_next;
                acc_hi_reg     <= acc_hi_next;
                seen_count_reg <= seen_count_next;
                first_err_reg  <= first_err_next;
                version_reg    <= version_next;
                suite_reg      <= suite_next;
            end
        end
    end

    // Extension type table, only entries below the count are ever compared
    always_ff @(posedge aclk) begin
        if (step && table_wr) begin
            seen_types_reg[seen_count_reg[SEEN_IDX_W-1:0]] <= pair_value;
        end
    end

endmodule

// ----- rtl/tls_hello_parser.sv -----
// Top level of the hello message parser: stream ports, input and result registers,
// layout register. Depends on tlsh_pkg and tlsh_core.
//
// Takes a hello message body one byte per item on the s_ stream (tlast on the final
// byte) and returns one item per byte on the m_ stream: the byte, its field tag in
// tuser and, on the last byte, the verdict with version and server suite. The block
// sustains one byte per clock while the result stream does not stall; each byte passes
// an input register and the result register. The parse state, including the 16-entry
// extension type compare, is computed combinationally between those registers. cfg_data
// selects client (1, reset) or server (0) layout and may only be changed between bodies;
// it is sampled when the session vector ends.
module tls_hello_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data,    // expect_client_hello
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tlsh_pkg::S_TDATA_W-1:0]  s_tdata,     // [7:0] in_byte
    input  logic                            s_tlast,     // last
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tlsh_pkg::M_TDATA_W-1:0]  m_tdata,     // [7:0] data_byte, [8] accepted,
                                                         // [11:9] error_code,
                                                         // [27:12] hello_version,
                                                         // [43:28] chosen_suite, [47:44] 0
    output logic [tlsh_pkg::M_TUSER_W-1:0]  m_tuser,     // [3:0] field_code
    output logic                            m_tlast      // done_res
);
    import tlsh_pkg::*;

    logic         expect_client_reg;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;
    logic         m_last_reg;
    logic         advance;
    logic         s_accept;
    tlsh_result_t res;

    // Configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_client_reg <= 1'b1;
        end else if (cfg_valid) begin
            expect_client_reg <= cfg_data;
        end
    end

    // Handshake: the result register frees the input register
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata[7:0];
            in_last_reg <= s_tlast;
        end
    end

    tlsh_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .in_byte       (in_byte_reg),
        .in_last       (in_last_reg),
        .expect_client (expect_client_reg),
        .res           (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {4'd0, res.suite, res.version, res.error_code,
                           res.accepted, in_byte_reg};
            m_user_reg <= res.field_code;
            m_last_reg <= res.done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- rtl/tlsh_checker.sv -----
// Port-level checks for tls_hello_parser and the bind that attaches them.
// Depends on tlsh_pkg.
module tlsh_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tlsh_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [tlsh_pkg::M_TUSER_W-1:0]  m_tuser,
    input logic                            m_tlast
);
    import tlsh_pkg::*;

    // A stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Verdict fields stay clear except on the last byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata[8] == 1'b0) && (m_tdata[11:9] == ERR_NONE))
        else $error("verdict on a byte that is not the last");

    // On the last byte, accept exactly when no error is reported
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata[8] == (m_tdata[11:9] == ERR_NONE)))
        else $error("accept flag disagrees with error code");

    // Tag is a defined field code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= M_TUSER_W'(FC_AFTER_ERR)))
        else $error("undefined field tag");

    // Input never stalls while the result side is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

bind tls_hello_parser tlsh_checker u_tlsh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- sim/tb_top.sv -----
// Testbench for tls_hello_parser: sends hello bodies byte by byte, predicts each tagged
// result item in a behavioral parser and compares all fields. Depends on rtl/tlsh_pkg.sv
// and the parser RTL; needs no files or arguments.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tlsh_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;     // [7:0] in_byte
    logic                 s_tlast;     // last
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;     // [7:0] data_byte, [8] accepted, [11:9] error_code,
                                       // [27:12] hello_version, [43:28] chosen_suite
    logic [M_TUSER_W-1:0] m_tuser;     // [3:0] field_code
    logic                 m_tlast;     // done_res

    // One predicted result item per byte
    typedef struct {
        field_code_t tag;
        logic [7:0]  data;
        logic        done;
        logic        ok;
        error_t      err;
        logic [15:0] version;
        logic [15:0] suite;
    } tagged_byte_t;

    tagged_byte_t tagged_bytes_q[$];
    logic [7:0]   body_q[$];
    logic [7:0]   ext_q[$];
    int           mismatches;
    int           send_idle_pct;
    int           stall_pct;

    // Predictor state
    phase_t      pp;
    logic [15:0] f_rem;
    logic [15:0] l_rem;
    logic [15:0] acc;
    logic [15:0] seen_tbl [MAX_EXTENSIONS];
    int          seen_n;
    error_t      first_err;
    logic [15:0] ver_q;
    logic [15:0] suite_q;
    logic        layout_client;

    tls_hello_parser i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_parse();
        pp        = PH_VER;
        f_rem     = '0;
        l_rem     = '0;
        acc       = '0;
        seen_n    = 0;
        first_err = ERR_NONE;
        ver_q     = '0;
        suite_q   = '0;
    endfunction

    function automatic void flag(error_t e);
        first_err = e;
        pp        = PH_ERR;
    endfunction

    function automatic void go(phase_t ph, logic [15:0] remaining);
        pp    = ph;
        f_rem = remaining;
    endfunction

    // 2-byte big-endian field; returns 1 on its second byte
    function automatic bit pair_done(logic [7:0] b);
        if (f_rem == 0) begin
            acc   = {8'h00, b};
            f_rem = 16'd1;
            return 1'b0;
        end
        acc   = {acc[7:0], b};
        f_rem = '0;
        return 1'b1;
    endfunction

    function automatic void end_of_session();
        go(layout_client ? PH_CSLEN : PH_SUITE, '0);
    endfunction

    function automatic void next_ext();
        go(l_rem == 0 ? PH_TAIL : PH_XTYPE, '0);
    endfunction

    // Duplicate check wins over table full
    function automatic void note_type(logic [15:0] t);
        for (int i = 0; i < seen_n; i++) begin
            if (seen_tbl[i] == t) begin
                flag(ERR_DUP_EXT);
                return;
            end
        end
        if (seen_n >= MAX_EXTENSIONS) begin
            flag(ERR_TABLE_FULL);
            return;
        end
        seen_tbl[seen_n] = t;
        seen_n++;
        go(PH_XDLEN, '0);
    endfunction

    function automatic field_code_t field_of(phase_t ph);
        case (ph)
            PH_VER:   return FC_VERSION;
            PH_RAND:  return FC_RANDOM;
            PH_SLEN:  return FC_SESS_LEN;
            PH_SESS:  return FC_SESS;
            PH_CSLEN: return FC_SUITES_LEN;
            PH_CS:    return FC_SUITES;
            PH_CMLEN: return FC_COMP_LEN;
            PH_CM:    return FC_COMP;
            PH_SUITE: return FC_SUITE;
            PH_SCOMP: return FC_COMP;
            PH_XLEN:  return FC_EXT_LIST_LEN;
            PH_XTYPE: return FC_EXT_TYPE;
            PH_XDLEN: return FC_EXT_LEN;
            PH_XDATA: return FC_EXT_DATA;
            default:  return FC_AFTER_ERR;
        endcase
    endfunction

    function automatic void advance(logic [7:0] b);
        case (pp)
            PH_VER: begin
                if (pair_done(b)) begin
                    ver_q = acc;
                    go(PH_RAND, RANDOM_LEN);
                end
            end
            PH_RAND: begin
                if (f_rem <= 1) go(PH_SLEN, '0);
                else f_rem--;
            end
            PH_SLEN: begin
                if (b > SESSION_MAX_LEN) flag(ERR_SESS_LONG);
                else if (b == 0) end_of_session();
                else go(PH_SESS, {8'h00, b});
            end
            PH_SESS: begin
                if (f_rem <= 1) end_of_session();
                else f_rem--;
            end
            PH_CSLEN: begin
                if (pair_done(b)) begin
                    if (acc == 0 || acc[0]) flag(ERR_SUITES_LEN);
                    else go(PH_CS, acc);
                end
            end
            PH_CS: begin
                if (f_rem <= 1) go(PH_CMLEN, '0);
                else f_rem--;
            end
            PH_CMLEN: begin
                if (b == 0) flag(ERR_COMP_EMPTY);
                else go(PH_CM, {8'h00, b});
            end
            PH_CM: begin
                if (f_rem <= 1) go(PH_XLEN, '0);
                else f_rem--;
            end
            PH_SUITE: begin
                if (pair_done(b)) begin
                    suite_q = acc;
                    go(PH_SCOMP, '0);
                end
            end
            PH_SCOMP: go(PH_XLEN, '0);
            PH_XLEN: begin
                if (pair_done(b)) begin
                    l_rem = acc;
                    next_ext();
                end
            end
            PH_XTYPE, PH_XDLEN, PH_XDATA: begin
                // every byte of an element is charged against the list length
                if (l_rem == 0) begin
                    flag(ERR_TRUNCATED);
                end else begin
                    l_rem--;
                    if (pp == PH_XDATA) begin
                        if (f_rem <= 1) next_ext();
                        else f_rem--;
                    end else if (!pair_done(b)) begin
                        if (l_rem == 0) flag(ERR_TRUNCATED);
                    end else if (pp == PH_XTYPE) begin
                        if (l_rem == 0) flag(ERR_TRUNCATED);
                        else note_type(acc);
                    end else begin
                        if (acc > l_rem) flag(ERR_TRUNCATED);
                        else if (acc == 0) next_ext();
                        else go(PH_XDATA, acc);
                    end
                end
            end
            PH_TAIL: flag(ERR_TRAILING);
            default: ;
        endcase
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic last);
        tagged_byte_t r;
        bit           at_end;
        r.tag = field_of(pp);
        advance(b);
        r.data = b;
        r.done = last;
        r.ok   = 1'b0;
        r.err  = ERR_NONE;
        if (last) begin
            at_end = (pp == PH_XLEN && f_rem == 0) || pp == PH_TAIL;
            if (first_err == ERR_NONE && !at_end) first_err = ERR_TRUNCATED;
            r.ok  = (first_err == ERR_NONE);
            r.err = first_err;
        end
        r.version = ver_q;
        r.suite   = suite_q;
        tagged_bytes_q.insert(tagged_bytes_q.size(), r);
        if (last) clear_parse();
    endfunction

    // ---------------------------------------------------------------- result check

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        tagged_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (tagged_bytes_q.size() == 0) begin
                $error("result item with no byte pending: tuser %0h tdata %0h", m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = tagged_bytes_q.pop_front();
                check_field("field_code", 16'(want.tag), 16'(m_tuser));
                check_field("data_byte", 16'(want.data), 16'(m_tdata[7:0]));
                check_field("done_res", 16'(want.done), 16'(m_tlast));
                check_field("accepted", 16'(want.ok), 16'(m_tdata[8]));
                check_field("error_code", 16'(want.err), 16'(m_tdata[11:9]));
                check_field("hello_version", want.version, m_tdata[27:12]);
                check_field("chosen_suite", want.suite, m_tdata[43:28]);
                check_field("tdata pad", 16'h0, 16'(m_tdata[47:44]));
            end
        end
    end

    // Receiver stalls at random
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= stall_pct);

    // ---------------------------------------------------------------- drivers

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        parse_byte(b, last);
        @(negedge aclk);
    endtask

    task automatic send_body();
        foreach (body_q[i]) send_byte(body_q[i], i == body_q.size() - 1);
        body_q.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tagged_bytes_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Layout register is only written with the parser idle
    task automatic write_layout(logic client);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= client;
        do @(posedge aclk); while (!cfg_ready);
        layout_client = client;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- body builders

    function automatic void body_add(logic [7:0] b);
        body_q.insert(body_q.size(), b);
    endfunction

    function automatic void ext_add(logic [7:0] b);
        ext_q.insert(ext_q.size(), b);
    endfunction

    task automatic add_bytes(int n);
        repeat (n) body_add(8'($urandom_range(255)));
    endtask

    task automatic add_pair(logic [15:0] v);
        body_add(v[15:8]);
        body_add(v[7:0]);
    endtask

    // version, random, session vector (a few bytes only when the length is illegal)
    task automatic add_opening(logic [15:0] ver, logic [7:0] sess_len);
        add_pair(ver);
        add_bytes(32);
        body_add(sess_len);
        add_bytes(sess_len > SESSION_MAX_LEN ? 4 : int'(sess_len));
    endtask

    task automatic add_client_part(logic [15:0] suites_len, logic [7:0] comp_len);
        add_pair(suites_len);
        add_bytes(int'(suites_len));
        body_add(comp_len);
        add_bytes(int'(comp_len));
    endtask

    task automatic add_server_part(logic [15:0] suite, logic [7:0] comp);
        add_pair(suite);
        body_add(comp);
    endtask

    task automatic add_ext(logic [15:0] ext_type, int dlen);
        ext_add(ext_type[15:8]);
        ext_add(ext_type[7:0]);
        ext_add(dlen[15:8]);
        ext_add(dlen[7:0]);
        repeat (dlen) ext_add(8'($urandom_range(255)));
    endtask

    task automatic close_ext_list(logic [15:0] list_len);
        add_pair(list_len);
        foreach (ext_q[i]) body_add(ext_q[i]);
        ext_q.delete();
    endtask

    // Mostly well-formed bodies with random content, some noise and broken ones
    task automatic build_random_body(logic client);
        int   roll;
        int   sess_len;
        int   n_ext;
        int   cut;
        bit   narrow_types;
        roll = $urandom_range(99);
        if (roll < 8) begin
            add_bytes($urandom_range(1, 60));
            return;
        end
        roll = $urandom_range(99);
        if (roll < 15) sess_len = 0;
        else if (roll < 30) sess_len = 32;
        else if (roll < 35) sess_len = $urandom_range(33, 255);
        else sess_len = $urandom_range(1, 31);
        add_opening(16'($urandom_range(16'hFFFF)), 8'(sess_len));
        roll = $urandom_range(99);
        if (!client) add_server_part(16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)));
        else if (roll < 4) add_client_part(16'd0, 8'($urandom_range(1, 3)));
        else if (roll < 8) add_client_part(16'(2 * $urandom_range(0, 7) + 1), 8'd1);
        else add_client_part(16'(2 * $urandom_range(1, 8)),
                             ($urandom_range(99) < 5) ? 8'd0 : 8'($urandom_range(1, 3)));
        roll = $urandom_range(99);
        if (roll >= 25) begin
            n_ext = (roll < 31) ? MAX_EXTENSIONS + $urandom_range(0, 1) : $urandom_range(0, 6);
            narrow_types = ($urandom_range(99) < 30);
            repeat (n_ext)
                add_ext(narrow_types ? 16'($urandom_range(0, 7)) : 16'($urandom_range(16'hFFFF)),
                        $urandom_range(0, 4));
            close_ext_list(16'(ext_q.size()));
        end
        // damage some bodies: cut short, trailing bytes, one byte overwritten
        roll = $urandom_range(99);
        if (roll < 12) begin
            cut = $urandom_range(1, body_q.size());
            while (body_q.size() > cut) void'(body_q.pop_back());
        end else if (roll < 20) begin
            add_bytes($urandom_range(1, 3));
        end else if (roll < 28) begin
            body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(255));
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_client_bodies();
        add_opening(16'h0000, 0);
        add_client_part(2, 1);
        send_body();
        // widest session, longer suite and compression vectors, empty extension list
        add_opening(16'hFFFF, 32);
        add_client_part(16'h0020, 8'h20);
        close_ext_list(0);
        send_body();
        add_opening(16'h0303, 5);
        add_client_part(4, 1);
        add_ext(16'h0000, 0);
        add_ext(16'hFFFF, 3);
        add_ext(16'h000A, 1);
        close_ext_list(16'(ext_q.size()));
        send_body();
    endtask

    task automatic test_session_limits();
        add_opening(16'h0303, 33);
        add_client_part(2, 1);
        send_body();
        add_opening(16'h0303, 8'hFF);
        add_bytes(3);
        send_body();
    endtask

    task automatic test_suite_errors();
        add_opening(16'h0301, 0);
        add_client_part(0, 1);
        send_body();
        add_opening(16'h0301, 1);
        add_client_part(3, 1);
        send_body();
    endtask

    task automatic test_compression_error();
        add_opening(16'h0302, 0);
        add_client_part(2, 0);
        add_bytes(2);
        send_body();
    endtask

    task automatic test_extension_errors();
        // duplicate type
        add_opening(16'h0303, 0);
        add_client_part(2, 1);
        add_ext(16'h0010, 1);
        add_ext(16'h0010, 0);
        close_ext_list(16'(ext_q.size()));
        send_body();
        // byte past a complete list
        add_opening(16'h0303, 0);
        add_client_part(2, 1);
        add_ext(16'h0001, 0);
        close_ext_list(16'(ext_q.size()));
        add_bytes(1);
        send_body();
        // data length beyond the rest of the list
        add_opening(16'h0303, 0);
        add_client_part(2, 1);
        add_ext(16'h0002, 5);
        close_ext_list(7);
        send_body();
        // type cut off by the list end
        add_opening(16'h0303, 0);
        add_client_part(2, 1);
        close_ext_list(1);
        add_bytes(1);
        send_body();
    endtask

    task automatic test_extension_table();
        // exactly full table passes, one more new type overflows, a repeat reports duplicate
        for (int n = MAX_EXTENSIONS; n <= MAX_EXTENSIONS + 1; n++) begin
            add_opening(16'h0303, 0);
            add_client_part(2, 1);
            for (int i = 0; i < n; i++) add_ext(16'(16'h0100 + i), i % 2);
            close_ext_list(16'(ext_q.size()));
            send_body();
        end
        add_opening(16'h0303, 0);
        add_client_part(2, 1);
        for (int i = 0; i < MAX_EXTENSIONS; i++) add_ext(16'(16'h0200 + i), 0);
        add_ext(16'h0205, 0);
        close_ext_list(16'(ext_q.size()));
        send_body();
    endtask

    task automatic test_truncated_bodies();
        add_bytes(1);
        send_body();
        add_pair(16'h0303);
        add_bytes(10);
        send_body();
        // list length says more follows
        add_opening(16'h0303, 0);
        add_client_part(2, 1);
        add_pair(16'h0004);
        send_body();
        // list length itself cut in half
        add_opening(16'h0303, 0);
        add_client_part(2, 1);
        add_bytes(1);
        send_body();
    endtask

    task automatic test_server_bodies();
        write_layout(1'b0);
        add_opening(16'h0303, 0);
        add_server_part(16'hFFFF, 8'h00);
        send_body();
        add_opening(16'h0301, 32);
        add_server_part(16'h0000, 8'hFF);
        add_ext(16'h0017, 2);
        add_ext(16'h002B, 0);
        close_ext_list(16'(ext_q.size()));
        send_body();
        add_opening(16'h0304, 0);
        add_server_part(16'h1301, 8'h00);
        add_bytes(1);
        send_body();
    endtask

    task automatic test_random_traffic();
        int sent;
        int idle_mix [4][2] = '{'{0, 0}, '{58, 0}, '{0, 58}, '{8, 8}};
        for (int ph = 0; ph < 4; ph++) begin
            write_layout(ph % 2 == 0);
            send_idle_pct = idle_mix[ph][0];
            stall_pct     = idle_mix[ph][1];
            sent = 0;
            while (sent < 40) begin
                // now and then a body laid out for the other hello kind
                build_random_body(($urandom_range(99) < 10) ? !layout_client : layout_client);
                sent += body_q.size();
                send_body();
            end
        end
        drain();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b1;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        mismatches    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        layout_client = 1'b1;
        clear_parse();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_client_bodies();
        test_session_limits();
        test_suite_errors();
        test_compression_error();
        test_extension_errors();
        test_extension_table();
        test_truncated_bodies();
        test_server_bodies();
        test_random_traffic();

        // let any stray result items show up
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- tls_hello_parser.f -----
rtl/tlsh_pkg.sv
rtl/tlsh_core.sv
rtl/tls_hello_parser.sv
rtl/tlsh_checker.sv
sim/tb_top.sv
